>>> rtl/mewd_pkg.sv
// Package for the Morse energy window decoder: shared constants, symbol codes,
// register indexes and the structs passed between front end, queue and back end.
// Depends on nothing.
package mewd_pkg;

    // Default parameter values
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WINDOW_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF  = 16;

    // Fixed register and accumulator widths
    localparam int ENERGY_W  = 43;
    localparam int WIN_LEN_W = 12;
    localparam int THRESH_W  = 16;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    // APB port
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;

    // Register indexes (byte address is 8 times the index)
    localparam logic [2:0] REG_WINDOW_LEN   = 3'd0;
    localparam logic [2:0] REG_SUM_MIN      = 3'd1;
    localparam logic [2:0] REG_DASH_MIN     = 3'd2;
    localparam logic [2:0] REG_LETTER_GAP   = 3'd3;
    localparam logic [2:0] REG_WORD_GAP     = 3'd4;

    // Register reset values
    localparam logic [WIN_LEN_W-1:0] WINDOW_LEN_RST = 12'd48;
    localparam logic [ENERGY_W-1:0]  SUM_MIN_RST    = 43'd48000048;
    localparam logic [THRESH_W-1:0]  DASH_MIN_RST   = 16'd20;
    localparam logic [THRESH_W-1:0]  LETTER_GAP_RST = 16'd30;
    localparam logic [THRESH_W-1:0]  WORD_GAP_RST   = 16'd70;

    // Event queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Output symbol codes
    typedef enum logic [1:0] {
        SYM_DOT        = 2'd0,
        SYM_DASH       = 2'd1,
        SYM_LETTER_GAP = 2'd2,
        SYM_WORD_GAP   = 2'd3
    } sym_t;

    // Configuration registers as seen by the front end
    typedef struct packed {
        logic [WIN_LEN_W-1:0] window_len;
        logic [ENERGY_W-1:0]  sum_min;
        logic [THRESH_W-1:0]  dash_min;
        logic [THRESH_W-1:0]  letter_gap;
        logic [THRESH_W-1:0]  word_gap;
    } cfg_t;

    // Symbols caused by one sample; cnt is 1 or 2 when queued
    typedef struct packed {
        logic [1:0] cnt;
        sym_t       sym0;
        sym_t       sym1;
    } evt_t;

    // Queue status toward the producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

>>> rtl/morse_energy_window_decoder_core.sv
// Throughput: one sample per cycle while the event queue has room; each symbol is one
// output word. A symbol passes, in order, the square register at the accepting edge,
// the window update into the event queue and the output register onto m_tdata. A second
// symbol from the same sample follows as the next output word; a full queue stalls
// s_tready. Reset: aresetn synchronous, active low; clears stream state, queue and
// output, and loads the register defaults. No clearing pass.
module morse_energy_window_decoder_core
    import mewd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int WINDOW_BITS = WINDOW_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Sample stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // [SAMPLE_BITS-1:0] sample
    input  logic                                s_tlast,  // end_of_stream
    // Symbol stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,  // [1:0] symbol
    output logic                                m_tlast,  // last_of_run
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [APB_ADDR_W-1:0]               paddr,
    input  logic [APB_DATA_W-1:0]               pwdata,
    output logic [APB_DATA_W-1:0]               prdata,
    output logic                                pready
);

    cfg_t   cfg_reg;
    qstat_t qstat;
    evt_t   evt;
    evt_t   head;
    logic   push;
    logic   pop;
    sym_t   m_symbol;
    logic   wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:3];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_len <= WINDOW_LEN_RST;
            cfg_reg.sum_min    <= SUM_MIN_RST;
            cfg_reg.dash_min   <= DASH_MIN_RST;
            cfg_reg.letter_gap <= LETTER_GAP_RST;
            cfg_reg.word_gap   <= WORD_GAP_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WINDOW_LEN: cfg_reg.window_len <= pwdata[WIN_LEN_W-1:0];
                REG_SUM_MIN:    cfg_reg.sum_min    <= pwdata[ENERGY_W-1:0];
                REG_DASH_MIN:   cfg_reg.dash_min   <= pwdata[THRESH_W-1:0];
                REG_LETTER_GAP: cfg_reg.letter_gap <= pwdata[THRESH_W-1:0];
                REG_WORD_GAP:   cfg_reg.word_gap   <= pwdata[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (reg_idx)
            REG_WINDOW_LEN: prdata = APB_DATA_W'(cfg_reg.window_len);
            REG_SUM_MIN:    prdata = APB_DATA_W'(cfg_reg.sum_min);
            REG_DASH_MIN:   prdata = APB_DATA_W'(cfg_reg.dash_min);
            REG_LETTER_GAP: prdata = APB_DATA_W'(cfg_reg.letter_gap);
            REG_WORD_GAP:   prdata = APB_DATA_W'(cfg_reg.word_gap);
            default:        prdata = '0;
        endcase
    end

    mewd_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW_BITS (WINDOW_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sample  (s_tdata[SAMPLE_BITS-1:0]),
        .eos     (s_tlast),
        .cfg     (cfg_reg),
        .qstat   (qstat),
        .push    (push),
        .evt     (evt)
    );

    mewd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_evt (evt),
        .pop      (pop),
        .head     (head),
        .stat     (qstat)
    );

    mewd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_symbol (m_symbol),
        .m_last   (m_tlast)
    );

    assign m_tdata = {6'b0, m_symbol};

    // Front end never writes into a full queue
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.full |-> !push)
        else $error("event pushed into full queue");

    // Back end never retires an entry from an empty queue
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.empty |-> !pop)
        else $error("event popped from empty queue");

    // A queued event carries one or two symbols
    a_evt_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (evt.cnt == 2'd1 || evt.cnt == 2'd2))
        else $error("queued event with bad symbol count");

endmodule

>>> rtl/mewd_front.sv
// Front end: accepts samples, squares them, accumulates window energy and
// classifies windows into tone runs and silence runs, queuing symbol events.
// Depends on mewd_pkg.
module mewd_front
    import mewd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int WINDOW_BITS = WINDOW_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   eos,
    input  cfg_t                   cfg,
    input  qstat_t                 qstat,
    output logic                   push,
    output evt_t                   evt
);

    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int SUM_W = (SQ_W > ENERGY_W ? SQ_W : ENERGY_W) + 1;
    localparam int WC_W  = WINDOW_BITS > WIN_LEN_W ? WINDOW_BITS : WIN_LEN_W;
    localparam int CC_W  = COUNT_BITS > THRESH_W ? COUNT_BITS : THRESH_W;

    // Square stage registers
    logic                   sq_valid_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic                   last_reg;

    // Stream state
    logic [ENERGY_W-1:0]    energy_reg, energy_next;
    logic [WINDOW_BITS-1:0] fill_reg, fill_next;
    logic [COUNT_BITS-1:0]  sil_reg, sil_next;
    logic [COUNT_BITS-1:0]  tone_reg, tone_next;
    logic                   in_tone_reg, in_tone_next;

    logic                   proc;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ_W-1:0]        sq_in;
    evt_t                   evt_c;

    // Magnitude of the sample; the most negative value maps to 2^(N-1)
    assign mag   = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    assign sq_in = SQ_W'(mag) * SQ_W'(mag);

    // Process the squared sample once the queue has room
    assign proc    = sq_valid_reg && !qstat.full;
    assign s_ready = !sq_valid_reg || proc;

    function automatic sym_t mark_of(input logic [COUNT_BITS-1:0] t,
                                     input logic [THRESH_W-1:0] dmin);
        mark_of = (CC_W'(t) >= CC_W'(dmin)) ? SYM_DASH : SYM_DOT;
    endfunction

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
        bump = (&c) ? c : c + 1'b1;
    endfunction

    // Window accumulate, close test and run bookkeeping
    always_comb begin
        logic [SUM_W-1:0]       sum_raw;
        logic [ENERGY_W-1:0]    sum_sat;
        logic [WINDOW_BITS-1:0] fill_inc;
        logic                   close;
        logic [1:0]             n;
        sym_t                   s0;
        sym_t                   s1;

        sum_raw  = SUM_W'(energy_reg) + SUM_W'(sq_reg);
        sum_sat  = (sum_raw > SUM_W'(ENERGY_MAX)) ? ENERGY_MAX : sum_raw[ENERGY_W-1:0];
        fill_inc = fill_reg + 1'b1;
        close    = (WC_W'(fill_inc) >= WC_W'(cfg.window_len)) || (fill_inc == '0)
                   || last_reg;

        energy_next  = sum_sat;
        fill_next    = fill_inc;
        sil_next     = sil_reg;
        tone_next    = tone_reg;
        in_tone_next = in_tone_reg;
        n  = 2'd0;
        s0 = SYM_DOT;
        s1 = SYM_DOT;

        if (close) begin
            if (sum_sat >= cfg.sum_min) begin
                if (!in_tone_reg) begin
                    if (CC_W'(sil_reg) >= CC_W'(cfg.word_gap)) begin
                        s0 = SYM_WORD_GAP;
                        n  = 2'd1;
                    end else if (CC_W'(sil_reg) >= CC_W'(cfg.letter_gap)) begin
                        s0 = SYM_LETTER_GAP;
                        n  = 2'd1;
                    end
                    sil_next     = '0;
                    in_tone_next = 1'b1;
                end
                tone_next = bump(tone_reg);
            end else begin
                if (in_tone_reg) begin
                    s0           = mark_of(tone_reg, cfg.dash_min);
                    n            = 2'd1;
                    tone_next    = '0;
                    in_tone_next = 1'b0;
                end
                sil_next = bump(sil_reg);
            end
            energy_next = '0;
            fill_next   = '0;
        end

        // End of stream: close an open tone, then clear the stream
        if (last_reg) begin
            if (in_tone_next) begin
                if (n == 2'd0) begin
                    s0 = mark_of(tone_next, cfg.dash_min);
                end else begin
                    s1 = mark_of(tone_next, cfg.dash_min);
                end
                n = n + 2'd1;
            end
            energy_next  = '0;
            fill_next    = '0;
            sil_next     = '0;
            tone_next    = '0;
            in_tone_next = 1'b0;
        end

        evt_c.cnt  = n;
        evt_c.sym0 = s0;
        evt_c.sym1 = s1;
    end

    assign push = proc && (evt_c.cnt != 2'd0);
    assign evt  = evt_c;

    // Control and stream state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
            energy_reg   <= '0;
            fill_reg     <= '0;
            sil_reg      <= '0;
            tone_reg     <= '0;
            in_tone_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                sq_valid_reg <= s_valid;
            end
            if (proc) begin
                energy_reg  <= energy_next;
                fill_reg    <= fill_next;
                sil_reg     <= sil_next;
                tone_reg    <= tone_next;
                in_tone_reg <= in_tone_next;
            end
        end
    end

    // Square stage payload
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            sq_reg   <= sq_in;
            last_reg <= eos;
        end
    end

endmodule

>>> rtl/mewd_queue.sv
// Short event queue between the front end and the back end.
// Depends on mewd_pkg.
module mewd_queue
    import mewd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  evt_t   push_evt,
    input  logic   pop,
    output evt_t   head,
    output qstat_t stat
);

    evt_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign head       = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_evt;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/mewd_back.sv
// Back end: unpacks queued events into single symbols on the output register,
// flagging the last symbol caused by a sample.
// Depends on mewd_pkg.
module mewd_back
    import mewd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  evt_t   head,
    input  qstat_t qstat,
    output logic   pop,
    output logic   m_valid,
    input  logic   m_ready,
    output sym_t   m_symbol,
    output logic   m_last
);

    logic m_valid_reg;
    sym_t sym_reg;
    logic last_reg;
    logic second_reg;
    logic load;
    logic split;

    assign load  = !m_valid_reg || m_ready;
    // First of two symbols: emit it without retiring the entry
    assign split = (head.cnt == 2'd2) && !second_reg;
    assign pop   = load && !qstat.empty && !split;

    assign m_valid  = m_valid_reg;
    assign m_symbol = sym_reg;
    assign m_last   = last_reg;

    // Output register and symbol phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            second_reg  <= 1'b0;
            sym_reg     <= SYM_DOT;
            last_reg    <= 1'b0;
        end else if (load) begin
            m_valid_reg <= !qstat.empty;
            if (!qstat.empty) begin
                if (split) begin
                    sym_reg    <= head.sym0;
                    last_reg   <= 1'b0;
                    second_reg <= 1'b1;
                end else begin
                    sym_reg    <= second_reg ? head.sym1 : head.sym0;
                    last_reg   <= 1'b1;
                    second_reg <= 1'b0;
                end
            end
        end
    end

endmodule

>>> tb/morse_energy_window_decoder_core_tb.sv
// Self-checking testbench for morse_energy_window_decoder_core: random and directed
// sample streams, an in-bench symbol predictor and APB register setup between phases.
// Depends on mewd_pkg and the core RTL.
module morse_energy_window_decoder_core_tb
    import mewd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [15:0] smp;
        logic        eos;
    } sample_word_t;

    typedef struct packed {
        sym_t symbol;
        logic last;
    } symbol_exp_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Words waiting for the driver, and symbols the decoder still owes
    sample_word_t sample_q[$];
    symbol_exp_t  symbol_q[$];

    // Predictor copy of registers and stream state
    cfg_t                cfg_model;
    logic [ENERGY_W-1:0] energy_acc;
    logic [11:0]         fill_cnt;
    logic [15:0]         quiet_cnt;
    logic [15:0]         mark_cnt;
    logic                tone_on;

    int  err_count      = 0;
    int  cycle_count    = 0;
    int  idle_pct       = 25;
    bit  no_idle        = 1'b0;
    int  long_hold_req  = 0;
    int  long_hold_seen = 0;
    int  s_gap          = 0;
    int  m_hold         = 0;
    logic s_took        = 1'b0;

    morse_energy_window_decoder_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [15:0] sample
        .s_tlast  (s_tlast),   // end_of_stream
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [1:0] symbol, [7:2] zero
        .m_tlast  (m_tlast),   // last_of_run
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("morse_energy_window_decoder_core_tb: errors");
            $finish;
        end
    end

    function automatic sym_t mark_kind();
        return (mark_cnt >= cfg_model.dash_min) ? SYM_DASH : SYM_DOT;
    endfunction

    function automatic logic [15:0] bump(input logic [15:0] c);
        return (c != 16'hFFFF) ? c + 16'd1 : c;
    endfunction

    // Energy window decode of one accepted sample; queues the symbols it causes
    task automatic predict_symbols(input logic [15:0] smp, input logic eos);
        logic [16:0]         mag;
        logic [ENERGY_W-1:0] sq;
        sym_t                found [2];
        int                  n;
        symbol_exp_t         e;
        mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
        sq  = ENERGY_W'(mag) * ENERGY_W'(mag);
        n   = 0;
        if (energy_acc > ENERGY_MAX - sq) energy_acc = ENERGY_MAX;
        else energy_acc = energy_acc + sq;
        fill_cnt = fill_cnt + 12'd1;
        // window closes on length, on wrap, or at end of stream
        if (fill_cnt >= cfg_model.window_len || fill_cnt == 12'd0 || eos) begin
            if (energy_acc >= cfg_model.sum_min) begin
                if (!tone_on) begin
                    if (quiet_cnt >= cfg_model.word_gap) begin
                        found[n] = SYM_WORD_GAP;
                        n++;
                    end else if (quiet_cnt >= cfg_model.letter_gap) begin
                        found[n] = SYM_LETTER_GAP;
                        n++;
                    end
                    quiet_cnt = '0;
                    tone_on   = 1'b1;
                end
                mark_cnt = bump(mark_cnt);
            end else begin
                if (tone_on) begin
                    found[n] = mark_kind();
                    n++;
                    mark_cnt = '0;
                    tone_on  = 1'b0;
                end
                quiet_cnt = bump(quiet_cnt);
            end
            energy_acc = '0;
            fill_cnt   = '0;
        end
        // final mark, then a fresh stream
        if (eos) begin
            if (tone_on) begin
                found[n] = mark_kind();
                n++;
            end
            energy_acc = '0;
            fill_cnt   = '0;
            quiet_cnt  = '0;
            mark_cnt   = '0;
            tone_on    = 1'b0;
        end
        for (int k = 0; k < n; k++) begin
            e.symbol = found[k];
            e.last   = (k == n - 1);
            symbol_q.insert(symbol_q.size(), e);
        end
    endtask

    // Input acceptance, prediction and result checking
    always @(posedge aclk) begin : monitor
        symbol_exp_t want;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) predict_symbols(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (symbol_q.size() == 0) begin
                    $error("unexpected symbol word: symbol %0d last %0b", m_tdata[1:0], m_tlast);
                    err_count++;
                end else begin
                    want = symbol_q.pop_front();
                    if (m_tdata[1:0] !== want.symbol) begin
                        $error("symbol: expected %0d, got %0d", want.symbol, m_tdata[1:0]);
                        err_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_run: expected %0b, got %0b", want.last, m_tlast);
                        err_count++;
                    end
                    if (m_tdata[7:2] !== 6'd0) begin
                        $error("tdata pad: expected 0, got %0h", m_tdata[7:2]);
                        err_count++;
                    end
                end
            end
        end
    end

    // Sample driver: holds a word until taken, idles in random bursts
    always @(negedge aclk) begin : driver
        sample_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_took)) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (!no_idle && $urandom_range(99, 0) < idle_pct) begin
                s_gap = $urandom_range(7, 0);
                s_tvalid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                w = sample_q.pop_front();
                s_tdata  <= w.smp;
                s_tlast  <= w.eos;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Symbol receiver: random stalls plus requested long hold-offs
    always @(negedge aclk) begin : receiver
        if (m_hold > 0) begin
            m_hold--;
            m_tready <= 1'b0;
        end else if (long_hold_req != long_hold_seen) begin
            long_hold_seen = long_hold_req;
            m_hold = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(99, 0) < idle_pct) begin
            m_hold = $urandom_range(7, 0);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_word(input logic [15:0] smp, input logic eos);
        sample_word_t w;
        w.smp = smp;
        w.eos = eos;
        sample_q.insert(sample_q.size(), w);
    endtask

    // Magnitude above threshold, random sign
    function automatic logic [15:0] loud(input int t);
        int m;
        m = $urandom_range(32767, t + 1);
        return $urandom_range(1, 0) ? 16'(-m) : 16'(m);
    endfunction

    // Magnitude at or below threshold, random sign
    function automatic logic [15:0] quiet(input int t);
        int m;
        m = $urandom_range(t, 0);
        return $urandom_range(1, 0) ? 16'(-m) : 16'(m);
    endfunction

    task automatic reg_check(input logic [2:0] idx, input logic [63:0] want);
        logic [63:0] got;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            $error("register %0d: expected %0h, got %0h", idx, want, got);
            err_count++;
        end
    endtask

    // APB write, mirror into the predictor, read back
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        logic [63:0] kept;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        kept = '0;
        case (idx)
            REG_WINDOW_LEN: begin
                cfg_model.window_len = val[WIN_LEN_W-1:0];
                kept = 64'(val[WIN_LEN_W-1:0]);
            end
            REG_SUM_MIN: begin
                cfg_model.sum_min = val[ENERGY_W-1:0];
                kept = 64'(val[ENERGY_W-1:0]);
            end
            REG_DASH_MIN: begin
                cfg_model.dash_min = val[THRESH_W-1:0];
                kept = 64'(val[THRESH_W-1:0]);
            end
            REG_LETTER_GAP: begin
                cfg_model.letter_gap = val[THRESH_W-1:0];
                kept = 64'(val[THRESH_W-1:0]);
            end
            REG_WORD_GAP: begin
                cfg_model.word_gap = val[THRESH_W-1:0];
                kept = 64'(val[THRESH_W-1:0]);
            end
            default: ;
        endcase
        reg_check(idx, kept);
    endtask

    task automatic set_all(input longint unsigned wlen, input longint unsigned smin,
                           input longint unsigned dash, input longint unsigned letter,
                           input longint unsigned word);
        reg_write(REG_WINDOW_LEN, wlen);
        reg_write(REG_SUM_MIN, smin);
        reg_write(REG_DASH_MIN, dash);
        reg_write(REG_LETTER_GAP, letter);
        reg_write(REG_WORD_GAP, word);
    endtask

    // Wait until all words are taken and all symbols are back, then let the pipe empty
    task automatic settle();
        while (sample_q.size() != 0 || s_tvalid || symbol_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Keyed letters with random content, plus noise and cut-off tones
    task automatic push_morse(input int budget, input int w, input int t);
        int made;
        int r;
        int nel;
        int len;
        made = 0;
        while (made < budget) begin
            r = $urandom_range(99, 0);
            if (r < 75) begin
                nel = $urandom_range(4, 1);
                for (int e = 0; e < nel; e++) begin
                    len = ($urandom_range(1, 0) ? 3 : 1) * w + $urandom_range(w / 2, 0);
                    repeat (len) push_word(loud(t), 1'b0);
                    made += len;
                    len = (e == nel - 1) ? ($urandom_range(1, 0) ? 7 : 3) * w : w;
                    repeat (len) push_word(quiet(t), 1'b0);
                    made += len;
                end
                if ($urandom_range(19, 0) == 0) begin
                    push_word(quiet(t), 1'b1);
                    made++;
                end
            end else if (r < 90) begin
                len = $urandom_range(10, 1);
                repeat (len) push_word(16'($urandom), $urandom_range(15, 0) == 0);
                made += len;
            end else begin
                len = $urandom_range(w, 1);
                repeat (len) push_word(loud(t), 1'b0);
                push_word(loud(t), $urandom_range(1, 0));
                made += len + 1;
            end
        end
    endtask

    initial begin : stimulus
        int w;
        int t;
        int letter;
        cfg_model.window_len = WINDOW_LEN_RST;
        cfg_model.sum_min    = SUM_MIN_RST;
        cfg_model.dash_min   = DASH_MIN_RST;
        cfg_model.letter_gap = LETTER_GAP_RST;
        cfg_model.word_gap   = WORD_GAP_RST;
        energy_acc = '0;
        fill_cnt   = '0;
        quiet_cnt  = '0;
        mark_cnt   = '0;
        tone_on    = 1'b0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Register defaults after reset
        reg_check(REG_WINDOW_LEN, 64'(WINDOW_LEN_RST));
        reg_check(REG_SUM_MIN, 64'(SUM_MIN_RST));
        reg_check(REG_DASH_MIN, 64'(DASH_MIN_RST));
        reg_check(REG_LETTER_GAP, 64'(LETTER_GAP_RST));
        reg_check(REG_WORD_GAP, 64'(WORD_GAP_RST));

        // Sample extremes at defaults; partial last window with a tone left open
        push_word(16'h0000, 1'b0);
        push_word(16'h7FFF, 1'b0);
        push_word(16'h8000, 1'b0);
        push_word(16'h0001, 1'b0);
        push_word(16'hFFFF, 1'b1);
        settle();

        // Zero window length and all-zero thresholds: gap at every tone start
        set_all(0, 0, 0, 0, 0);
        push_word(16'h0005, 1'b1);
        push_word(16'h0000, 1'b0);
        push_word(16'h0000, 1'b1);
        settle();

        // Largest minimum: nothing counts as tone
        set_all(1, ENERGY_MAX, 0, 0, 0);
        push_word(16'h7FFF, 1'b0);
        push_word(16'h8000, 1'b1);
        settle();

        // Letter gaps, dash and dot by length
        set_all(1, 1, 2, 2, 16'hFFFF);
        push_word(16'h0000, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'h0064, 1'b0);
        push_word(16'h0064, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'hFF9C, 1'b1);
        settle();

        // Backpressure: long receiver hold while every word yields a symbol
        set_all(1, 1, 1, 0, 16'hFFFF);
        for (int i = 0; i < 60; i++)
            push_word((i % 2 == 0) ? loud(1000) : 16'h0000, i == 59);
        long_hold_req++;
        settle();

        // Partial last window measured against the full-window minimum
        set_all(40, 40 * 10001, 1, 0, 1);
        repeat (40) push_word(loud(100), 1'b0);
        repeat (40) push_word(quiet(9), 1'b0);
        repeat (20) push_word(loud(100), 1'b0);
        push_word(loud(100), 1'b1);
        settle();

        // Random keyed streams over several settings, last one without idling
        for (int p = 0; p < 6; p++) begin
            w = (p == 2) ? $urandom_range(24, 7) : $urandom_range(6, 1);
            t = $urandom_range(20000, 100);
            letter = $urandom_range(4, 1);
            set_all(w, (longint'(t) * t + 1) * w, $urandom_range(4, 2), letter,
                    letter + $urandom_range(5, 1));
            if (p == 5) no_idle = 1'b1;
            push_morse(230, w, t);
            settle();
        end

        if (err_count == 0) begin
            $display("morse_energy_window_decoder_core_tb: clean");
        end else begin
            $display("morse_energy_window_decoder_core_tb: errors");
        end
        $finish;
    end

endmodule

>>> morse_energy_window_decoder_core.f
rtl/mewd_pkg.sv
rtl/mewd_front.sv
rtl/mewd_queue.sv
rtl/mewd_back.sv
rtl/morse_energy_window_decoder_core.sv
tb/morse_energy_window_decoder_core_tb.sv
